### src/fsp_pkg.sv
`default_nettype none

package fsp_pkg;

    // Geometry of the occupancy memory
    localparam int WORD_BITS         = 32;
    localparam int OFF_W             = $clog2(WORD_BITS);
    localparam int MAX_SLOTS_DEFAULT = 256;

    // Field widths
    localparam int MODE_W         = 2;
    localparam int SLOT_W         = 8;
    localparam int RECORD_COUNT_W = 9;

    localparam logic [RECORD_COUNT_W-1:0] RECORD_COUNT_RESET = 9'd256;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_FIND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_USED = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] free_slot;
    } res_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL
    } state_t;

endpackage

`default_nettype wire

### src/fsp_bitmap_mem.sv
`default_nettype none

module fsp_bitmap_mem #(
    parameter int NUM_WORDS = 8,
    parameter int ADDR_W    = 3
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire fsp_pkg::mem_ctl_t            ctl,
    input  wire logic [ADDR_W-1:0]            addr,
    input  wire logic [fsp_pkg::WORD_BITS-1:0] wr_data,
    output logic      [fsp_pkg::WORD_BITS-1:0] rd_data
);

    logic [fsp_pkg::WORD_BITS-1:0] mem_reg [NUM_WORDS];
    logic [fsp_pkg::WORD_BITS-1:0] rd_data_reg;
    logic                          rd_valid_reg;
    logic [NUM_WORDS-1:0]          row_valid_reg;

    // Mark rows as written; a row never written reads as all free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
        end else if (ctl.wr_en) begin
            row_valid_reg[addr] <= 1'b1;
        end
    end

    // Write port
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem_reg[addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg  <= mem_reg[addr];
            rd_valid_reg <= row_valid_reg[addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

### src/fsp_word_scan.sv
`default_nettype none

module fsp_word_scan #(
    parameter int ADDR_W = 3,
    parameter int CNT_W  = 9
) (
    input  wire logic [fsp_pkg::WORD_BITS-1:0] word,
    input  wire logic [ADDR_W-1:0]             addr,
    input  wire logic [CNT_W-1:0]              eff_count,
    output logic                               hit,
    output logic [fsp_pkg::SLOT_W-1:0]         hit_slot
);

    localparam int IDX_W = ADDR_W + fsp_pkg::OFF_W;
    localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam int EXT_W = (IDX_W > fsp_pkg::SLOT_W) ? IDX_W : fsp_pkg::SLOT_W;

    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] bit_idx;
    logic [EXT_W-1:0] hit_ext;

    // Find lowest free bit whose slot lies below the effective count
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        bit_idx = '0;
        for (int b = fsp_pkg::WORD_BITS - 1; b >= 0; b--) begin
            bit_idx = {addr, fsp_pkg::OFF_W'(b)};
            if (!word[b] && (CMP_W'(bit_idx) < CMP_W'(eff_count))) begin
                hit     = 1'b1;
                hit_idx = bit_idx;
            end
        end
    end

    // Report the low byte of the slot index, zero on a miss
    assign hit_ext  = EXT_W'(hit_idx);
    assign hit_slot = hit_ext[fsp_pkg::SLOT_W-1:0];

endmodule

`default_nettype wire

### src/free_slot_bitmap_allocator.sv
`default_nettype none

// Mark requests in range pass through the read and modify-write states before the next ready; marks out of
// range and the unused mode are dropped.
// Find scans W of the 32-bit words (1 to ceil(MAX_SLOTS/32)), with one read and one evaluate state
// each, and stops at the first hit or the last word; its result is registered after the last evaluate.
// The last evaluate holds while an earlier result still waits in the output register.
// Reset (synchronous, active low) clears per-word valid flags, sets record_count to 256.
module free_slot_bitmap_allocator #(
    parameter int MAX_SLOTS = fsp_pkg::MAX_SLOTS_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [fsp_pkg::RECORD_COUNT_W-1:0]  cfg_wr_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire fsp_pkg::req_t                       s_req,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output fsp_pkg::res_t                            m_res
);

    localparam int NUM_WORDS = (MAX_SLOTS + fsp_pkg::WORD_BITS - 1) / fsp_pkg::WORD_BITS;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W     = ($clog2(MAX_SLOTS + 1) > fsp_pkg::RECORD_COUNT_W) ?
                               $clog2(MAX_SLOTS + 1) : fsp_pkg::RECORD_COUNT_W;
    localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_SLOTS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_WORDS - 1);

    fsp_pkg::state_t                       state_reg, state_next;
    logic [ADDR_W-1:0]                     addr_reg, addr_next;
    logic [fsp_pkg::MODE_W-1:0]            mode_reg, mode_next;
    logic [fsp_pkg::OFF_W-1:0]             off_reg, off_next;
    logic [fsp_pkg::RECORD_COUNT_W-1:0]    record_count_reg;
    logic                                  m_valid_reg, m_valid_next;
    fsp_pkg::res_t                         m_res_reg, m_res_next;

    logic [CNT_W-1:0]                      rc_ext;
    logic [CNT_W-1:0]                      eff_count;
    logic [CNT_W-1:0]                      slot_ext;
    logic [CNT_W-1:0]                      slot_shift;
    logic                                  slot_in_range;
    logic                                  out_free;
    logic                                  is_mark;

    fsp_pkg::mem_ctl_t                     mem_ctl;
    logic [fsp_pkg::WORD_BITS-1:0]         rd_data;
    logic [fsp_pkg::WORD_BITS-1:0]         wr_data;
    logic                                  hit;
    logic [fsp_pkg::SLOT_W-1:0]            hit_slot;

    // Effective count is the smaller of the register and the capacity
    assign rc_ext        = CNT_W'(record_count_reg);
    assign eff_count     = (rc_ext > MAX_CNT) ? MAX_CNT : rc_ext;
    assign slot_ext      = CNT_W'(s_req.slot);
    assign slot_shift    = slot_ext >> fsp_pkg::OFF_W;
    assign slot_in_range = slot_ext < eff_count;
    assign is_mark       = (s_req.mode == fsp_pkg::MODE_FREE) ||
                           (s_req.mode == fsp_pkg::MODE_USED);
    assign out_free      = !m_valid_reg || m_ready;

    // Hold the configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            record_count_reg <= fsp_pkg::RECORD_COUNT_RESET;
        end else if (cfg_wr_en) begin
            record_count_reg <= cfg_wr_data;
        end
    end

    // Control and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fsp_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Operation and result payload
    always_ff @(posedge aclk) begin
        addr_reg  <= addr_next;
        mode_reg  <= mode_next;
        off_reg   <= off_next;
        m_res_reg <= m_res_next;
    end

    // Sequence one request through read and evaluate, and write back for a mark
    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        mode_next     = mode_reg;
        off_next      = off_reg;
        m_res_next    = m_res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        mem_ctl.rd_en = 1'b0;
        mem_ctl.wr_en = 1'b0;
        wr_data       = rd_data;
        s_ready       = 1'b0;

        unique case (state_reg)
            fsp_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                mode_next = s_req.mode;
                off_next  = slot_ext[fsp_pkg::OFF_W-1:0];
                if (s_valid) begin
                    if (s_req.mode == fsp_pkg::MODE_FIND) begin
                        addr_next  = '0;
                        state_next = fsp_pkg::ST_READ;
                    end else if (is_mark && slot_in_range) begin
                        addr_next  = slot_shift[ADDR_W-1:0];
                        state_next = fsp_pkg::ST_READ;
                    end
                end
            end
            fsp_pkg::ST_READ: begin
                mem_ctl.rd_en = 1'b1;
                state_next    = fsp_pkg::ST_EVAL;
            end
            fsp_pkg::ST_EVAL: begin
                if (mode_reg == fsp_pkg::MODE_FIND) begin
                    if (hit || (addr_reg == LAST_ADDR)) begin
                        // Deliver once the result register is free
                        if (out_free) begin
                            m_valid_next         = 1'b1;
                            m_res_next.found     = hit;
                            m_res_next.free_slot = hit_slot;
                            state_next           = fsp_pkg::ST_IDLE;
                        end
                    end else begin
                        addr_next  = addr_reg + ADDR_W'(1);
                        state_next = fsp_pkg::ST_READ;
                    end
                end else begin
                    // Set or clear the slot bit and write the word back
                    wr_data[off_reg] = (mode_reg == fsp_pkg::MODE_USED);
                    mem_ctl.wr_en    = 1'b1;
                    state_next       = fsp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fsp_pkg::ST_IDLE;
            end
        endcase
    end

    fsp_bitmap_mem #(
        .NUM_WORDS (NUM_WORDS),
        .ADDR_W    (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mem_ctl),
        .addr    (addr_reg),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    fsp_word_scan #(
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_scan (
        .word      (rd_data),
        .addr      (addr_reg),
        .eff_count (eff_count),
        .hit       (hit),
        .hit_slot  (hit_slot)
    );

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    // A new result only comes out of the evaluate step of a find
    a_result_from_find: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |->
            $past(state_reg == fsp_pkg::ST_EVAL) && $past(mode_reg == fsp_pkg::MODE_FIND))
        else $error("result produced outside a find evaluation");

    // A miss always reports slot zero
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_res_reg.found |-> m_res_reg.free_slot == '0)
        else $error("miss carries a nonzero slot");

    // Write back only happens for a mark request
    a_write_on_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_ctl.wr_en |-> (state_reg == fsp_pkg::ST_EVAL) && (mode_reg != fsp_pkg::MODE_FIND))
        else $error("memory written outside a mark request");

    // Every read is followed by an evaluate cycle
    a_read_then_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == fsp_pkg::ST_READ |=> state_reg == fsp_pkg::ST_EVAL)
        else $error("read not followed by evaluation");

endmodule

`default_nettype wire
